@@ src/sws_pkg.sv @@
// Shared constants and types for the single-wire sensor frame decoder.
package sws_pkg;

  localparam int unsigned TIMER_BITS_DEF = 16;
  localparam int unsigned EDGE_TIME_W    = 16;
  localparam int unsigned THR_W          = 16;
  localparam int unsigned CNT_W          = 6;
  localparam int unsigned DATA_W         = 40;
  localparam int unsigned BYTE_W         = 8;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd4000;
  localparam logic [CNT_W-1:0] FIRST_BIT_EDGE  = 6'd3;
  localparam logic [CNT_W-1:0] FRAME_EDGES     = 6'd42;

  typedef enum logic {
    REQ_EDGE    = 1'b0,
    REQ_RESTART = 1'b1
  } req_type_e;

  // Frame progress carried between the state registers and the step logic.
  typedef struct packed {
    logic [CNT_W-1:0]  edge_count;
    logic [DATA_W-1:0] bit_shift;
  } frame_state_t;

  // One decoded frame; the bytes are declared last-received first, so the first byte off the wire is lowest.
  typedef struct packed {
    logic              data_ok;
    logic [BYTE_W-1:0] sum_byte;
    logic [BYTE_W-1:0] temp_frac;
    logic [BYTE_W-1:0] temp_int;
    logic [BYTE_W-1:0] humidity_frac;
    logic [BYTE_W-1:0] humidity_int;
  } result_t;

endpackage

@@ src/sws_frame_step.sv @@
// Next-state and result logic for one accepted beat of the frame decoder.
module sws_frame_step #(
  parameter int unsigned TIMER_BITS = sws_pkg::TIMER_BITS_DEF
) (
  input  sws_pkg::req_type_e                       req_type_i,
  input  logic [sws_pkg::EDGE_TIME_W-1:0]          edge_time_i,
  input  logic [sws_pkg::THR_W-1:0]                threshold_i,
  input  sws_pkg::frame_state_t                    state_i,
  input  logic [((TIMER_BITS < sws_pkg::EDGE_TIME_W) ?
                 TIMER_BITS : sws_pkg::EDGE_TIME_W)-1:0] last_time_i,
  output sws_pkg::frame_state_t                    state_o,
  output logic [((TIMER_BITS < sws_pkg::EDGE_TIME_W) ?
                 TIMER_BITS : sws_pkg::EDGE_TIME_W)-1:0] last_time_o,
  output logic                                     res_valid_o,
  output sws_pkg::result_t                         res_o
);

  localparam int unsigned TB_IN = (TIMER_BITS < sws_pkg::EDGE_TIME_W) ?
                                  TIMER_BITS : sws_pkg::EDGE_TIME_W;
  localparam int unsigned CMP_W = (TIMER_BITS > sws_pkg::THR_W) ?
                                  TIMER_BITS : sws_pkg::THR_W;

  logic [TIMER_BITS-1:0]          now;
  logic [TIMER_BITS-1:0]          interval;
  logic                           bit_one;
  logic [sws_pkg::CNT_W-1:0]      cnt_inc;
  logic [sws_pkg::DATA_W-1:0]     shifted;
  logic [sws_pkg::BYTE_W-1:0]     total;

  // The interval wraps with the timer, so plain modular subtraction suffices.
  assign now      = TIMER_BITS'(edge_time_i[TB_IN-1:0]);
  assign interval = now - TIMER_BITS'(last_time_i);
  assign bit_one  = CMP_W'(interval) >= CMP_W'(threshold_i);
  assign cnt_inc  = state_i.edge_count + sws_pkg::CNT_W'(1);
  assign shifted  = {state_i.bit_shift[sws_pkg::DATA_W-2:0], bit_one};

  always_comb begin
    res_o.humidity_int  = shifted[39:32];
    res_o.humidity_frac = shifted[31:24];
    res_o.temp_int      = shifted[23:16];
    res_o.temp_frac     = shifted[15:8];
    res_o.sum_byte      = shifted[7:0];
    total = shifted[39:32] + shifted[31:24] + shifted[23:16] + shifted[15:8];
    res_o.data_ok = (total == shifted[7:0]);
  end

  always_comb begin
    state_o     = state_i;
    last_time_o = last_time_i;
    res_valid_o = 1'b0;
    unique case (req_type_i)
      sws_pkg::REQ_RESTART: begin
        state_o     = '0;
        last_time_o = '0;
      end
      sws_pkg::REQ_EDGE: begin
        last_time_o        = edge_time_i[TB_IN-1:0];
        state_o.edge_count = cnt_inc;
        if (cnt_inc >= sws_pkg::FIRST_BIT_EDGE) begin
          state_o.bit_shift = shifted;
          if (cnt_inc >= sws_pkg::FRAME_EDGES) begin
            res_valid_o = 1'b1;
            state_o     = '0;
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

@@ src/sws_out_buf.sv @@
// Two-entry output register with skid slot for decoded frames.
module sws_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sws_pkg::result_t push_data_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output sws_pkg::result_t data_o
);

  logic             main_valid_q, main_valid_d;
  logic             skid_valid_q, skid_valid_d;
  sws_pkg::result_t main_q, main_d;
  sws_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop     = main_valid_q && ready_i;
  assign space_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // Nothing is pushed while the skid slot is occupied.
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!main_valid_q || pop) begin
      main_valid_d = push_i;
      main_d       = push_i ? push_data_i : main_q;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid slot holds a frame while the output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_valid_q && !ready_i && !skid_valid_q && push_i) |=> skid_valid_q)
    else $error("frame pushed during a stall was not caught by the skid slot");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && pop) |=> (main_valid_q && !skid_valid_q && main_q == $past(skid_q)))
    else $error("skid slot did not move into the output register");

endmodule

@@ src/single_wire_sensor_frame_decoder.sv @@
// Top level of the single-wire humidity and temperature sensor frame decoder.
//
// Each input beat is either a rising edge of the sensor line, carrying the
// free-running timer value captured at that edge, or a restart (tuser high)
// that clears the frame in progress. The decoder measures the time between
// successive edges modulo 2^TIMER_BITS, so a timer wrap inside a frame is
// harmless. The intervals ahead of the first data bit, among them the sensor's
// response pulse, are dropped; each of the next 40 intervals becomes one data
// bit, most significant first, and reads as one when it is at or above the
// bit threshold register (reset value 4000 counts). Once the last bit is in, one
// output beat carries the five received bytes and a flag that says whether
// the low byte of the sum of the first four matches the checksum byte; the
// decoder then rearms, keeping the last edge's time as its reference. The step
// logic for each input beat is one subtract, one compare and one shift applied
// straight to the frame registers, so a new beat is accepted in every cycle
// while the output has space. Results pass through an output register backed
// by a skid slot, so input beats keep flowing while a finished frame waits at
// the output; the input stalls only when both slots hold frames. The threshold
// is written through cfg_we_i and cfg_wdata_i and should change only while the
// block is idle.
module single_wire_sensor_frame_decoder #(
  parameter int unsigned TIMER_BITS = sws_pkg::TIMER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: bit threshold in timer counts.
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] edge_time
  input  logic        s_axis_tuser,   // [0] req_type
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] humidity_int, [15:8] humidity_frac,
                                      // [23:16] temp_int, [31:24] temp_frac,
                                      // [39:32] sum_byte
  output logic        m_axis_tuser    // [0] data_ok
);

  // Only the timer bits that the edge field can carry are ever stored.
  localparam int unsigned TB_IN = (TIMER_BITS < sws_pkg::EDGE_TIME_W) ?
                                  TIMER_BITS : sws_pkg::EDGE_TIME_W;

  logic [sws_pkg::THR_W-1:0] threshold_q;
  sws_pkg::frame_state_t     state_q, state_d;
  logic [TB_IN-1:0]          last_time_q, last_time_d;
  logic                      accept;
  logic                      res_valid;
  sws_pkg::result_t          res;
  sws_pkg::result_t          out_res;
  logic                      buf_space;
  sws_pkg::req_type_e        req_type;

  assign req_type      = sws_pkg::req_type_e'(s_axis_tuser);
  assign s_axis_tready = buf_space;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= sws_pkg::THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  sws_frame_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .req_type_i  (req_type),
    .edge_time_i (s_axis_tdata),
    .threshold_i (threshold_q),
    .state_i     (state_q),
    .last_time_i (last_time_q),
    .state_o     (state_d),
    .last_time_o (last_time_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Frame registers advance only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      last_time_q <= '0;
    end else if (accept) begin
      state_q     <= state_d;
      last_time_q <= last_time_d;
    end
  end

  sws_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .space_o     (buf_space),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = {out_res.sum_byte, out_res.temp_frac, out_res.temp_int,
                         out_res.humidity_frac, out_res.humidity_int};
  assign m_axis_tuser = out_res.data_ok;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.edge_count < sws_pkg::FRAME_EDGES)
    else $error("edge count ran past the end of a frame");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser) |=> (state_q == '0 && last_time_q == '0))
    else $error("restart beat did not clear the frame");

  a_frame_end_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_valid) |=> (state_q.edge_count == '0 && m_axis_tvalid))
    else $error("end of frame did not rearm or did not present a result");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the single-wire sensor frame decoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A long receiver hold-off must let the decoder fill both output slots.
  localparam int HOLD_CYCLES = 400;
  // Cycles with no beat on either side before the run is declared hung.
  localparam int QUIET_LIMIT = 3000;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // [15:0] edge_time
  logic        s_axis_tuser  = 1'b0;  // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;  // [7:0] humidity_int, [15:8] humidity_frac, [23:16] temp_int,
                              // [31:24] temp_frac, [39:32] sum_byte
  logic        m_axis_tuser;  // [0] data_ok

  single_wire_sensor_frame_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Our own copy of the decoder state, advanced once per accepted input beat.
  logic [15:0]                threshold  = sws_pkg::THRESHOLD_RESET;
  logic [sws_pkg::CNT_W-1:0]  edge_cnt   = '0;
  logic [15:0]                prev_stamp = '0;
  logic [sws_pkg::DATA_W-1:0] rx_bits    = '0;

  sws_pkg::result_t pending_frames[$];  // decoded frames still owed by the block
  int      beats_sent  = 0;
  int      mismatches  = 0;
  bit      tx_bursts   = 1'b1;
  bit      rx_bursts   = 1'b1;
  bit      hold_long   = 1'b0;

  // One directed frame: threshold to run it at, whether a restart leads it, the time of its
  // first edge, the response pulse interval, the 40 bits to send, whether bit intervals sit
  // exactly on the threshold boundary, an optional abort point, and a hand-typed result.
  typedef struct {
    logic [15:0]      thr;
    bit               lead_restart;
    logic [15:0]      t0;
    logic [15:0]      resp;
    logic [39:0]      pattern;
    bit               exact;
    int               stop_after;
    bit               typed;
    sws_pkg::result_t want;
  } frame_row_t;

  frame_row_t plan [12];

  // Splits the 40 received bits into the five bytes in wire order.
  function automatic sws_pkg::result_t frame_from_bits(input logic [39:0] w, input logic ok);
    sws_pkg::result_t r;
    r.humidity_int  = w[39:32];
    r.humidity_frac = w[31:24];
    r.temp_int      = w[23:16];
    r.temp_frac     = w[15:8];
    r.sum_byte      = w[7:0];
    r.data_ok       = ok;
    return r;
  endfunction

  // Advances the shadow decoder by one beat; returns 1 when the beat completes a frame.
  function automatic bit decode_edge(input sws_pkg::req_type_e kind, input logic [15:0] stamp,
                                     output sws_pkg::result_t frame);
    logic [15:0]                gap;
    logic [sws_pkg::BYTE_W-1:0] total;
    frame = '0;
    if (kind == sws_pkg::REQ_RESTART) begin
      edge_cnt   = '0;
      rx_bits    = '0;
      prev_stamp = '0;
      return 1'b0;
    end
    // Subtraction at the timer width takes care of a wrap between edges.
    gap        = stamp - prev_stamp;
    prev_stamp = stamp;
    edge_cnt   = edge_cnt + 1'b1;
    // The first edge only marks time and the response pulse is thrown away.
    if (edge_cnt < sws_pkg::FIRST_BIT_EDGE) return 1'b0;
    rx_bits = {rx_bits[sws_pkg::DATA_W-2:0], gap >= threshold};
    if (edge_cnt < sws_pkg::FRAME_EDGES) return 1'b0;
    total = rx_bits[39:32] + rx_bits[31:24] + rx_bits[23:16] + rx_bits[15:8];
    frame = frame_from_bits(rx_bits, total == rx_bits[7:0]);
    // The frame rearms, but the time of this edge stays as the reference.
    edge_cnt = '0;
    rx_bits  = '0;
    return 1'b1;
  endfunction

  // Interval that makes the decoder read the wanted bit at a nonzero threshold. Boundary
  // values are favored since the compare is at-or-above.
  function automatic logic [15:0] pick_gap(input logic b, input bit exact);
    if (threshold == 0) return 16'($urandom_range(65535, 0));  // every interval reads as one
    if (b) return (exact || $urandom_range(3) == 0) ? threshold
                                                    : 16'($urandom_range(65535, threshold));
    return (exact || $urandom_range(3) == 0) ? threshold - 1'b1
                                             : 16'($urandom_range(threshold - 1, 0));
  endfunction

  // Four random data bytes followed by a matching or a random checksum byte.
  function automatic logic [39:0] rand_pattern(input bit good);
    logic [31:0] payload;
    logic [7:0]  chk;
    payload = $urandom;
    chk     = payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0];
    return {payload, good ? chk : 8'($urandom)};
  endfunction

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(300, 1));
      2: return $urandom_range(1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom_range(8000, 1500));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [40:0] got,
                                 input logic [40:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    end
  endtask

  // Offers one beat, possibly after an idle burst, and waits until the decoder takes it.
  task automatic send_beat(input sws_pkg::req_type_e kind, input logic [15:0] stamp,
                           input bit typed, input sws_pkg::result_t want);
    sws_pkg::result_t frame;
    if (tx_bursts && $urandom_range(4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= stamp;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    if (decode_edge(kind, stamp, frame)) begin
      pending_frames.push_back(typed ? want : frame);
    end
  endtask

  // Sends all edges of one frame, led by a restart when asked. A nonzero stop_after aborts
  // the frame with a restart in place of that edge.
  task automatic send_frame(input bit lead_restart, input logic [15:0] t0,
                            input logic [15:0] resp, input logic [39:0] pattern,
                            input bit exact, input int stop_after, input bit typed,
                            input sws_pkg::result_t want);
    logic [15:0] stamp;
    if (lead_restart) send_beat(sws_pkg::REQ_RESTART, 16'($urandom), 1'b0, want);
    stamp = t0;
    for (int n = 0; n < sws_pkg::FRAME_EDGES; n++) begin
      if (stop_after != 0 && n == stop_after) begin
        send_beat(sws_pkg::REQ_RESTART, 16'($urandom), 1'b0, want);
        return;
      end
      if (n == 1) stamp = stamp + resp;
      else if (n >= 2) stamp = stamp + pick_gap(pattern[41-n], exact);
      send_beat(sws_pkg::REQ_EDGE, stamp, typed, want);
    end
  endtask

  // Holds the input side idle until every owed frame has come out.
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_frames.size() != 0) @(posedge clk_i);
  endtask

  // The threshold only changes while the decoder is idle; the extra wait covers the
  // step register and the output slots.
  task automatic set_threshold(input logic [15:0] value);
    drain_wait();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    threshold = value;
  endtask

  // Each output beat is compared field by field with the oldest owed frame.
  task automatic check_frame(input sws_pkg::result_t got);
    sws_pkg::result_t want;
    if (pending_frames.size() == 0) begin
      report_mismatch("unexpected frame", got, '0);
      return;
    end
    want = pending_frames.pop_front();
    if (got.humidity_int != want.humidity_int)
      report_mismatch("humidity_int", 41'(got.humidity_int), 41'(want.humidity_int));
    if (got.humidity_frac != want.humidity_frac)
      report_mismatch("humidity_frac", 41'(got.humidity_frac), 41'(want.humidity_frac));
    if (got.temp_int != want.temp_int)
      report_mismatch("temp_int", 41'(got.temp_int), 41'(want.temp_int));
    if (got.temp_frac != want.temp_frac)
      report_mismatch("temp_frac", 41'(got.temp_frac), 41'(want.temp_frac));
    if (got.sum_byte != want.sum_byte)
      report_mismatch("sum_byte", 41'(got.sum_byte), 41'(want.sum_byte));
    if (got.data_ok != want.data_ok)
      report_mismatch("data_ok", 41'(got.data_ok), 41'(want.data_ok));
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request from the stimulus.
  initial begin
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_bursts && $urandom_range(4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(7, 1)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_frame({m_axis_tuser, m_axis_tdata});
    end
  end

  // Watchdog: a run with no beat on either side for too long has hung.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int step;
    int kind;

    // Directed frames. Rows with a typed result are plain enough to read off by hand: all
    // zeros, all ones, checksum wrapping past 256, a wrong checksum, and the threshold
    // extremes where every interval reads as one or only the longest does.
    plan = '{
      '{16'd4000,  1'b1, 16'd0,     16'd0,     40'h00_00_00_00_00, 1'b1, 0,  1'b1,
        frame_from_bits(40'h00_00_00_00_00, 1'b1)},
      // Follows the previous frame with no restart; the response pulse is the longest.
      '{16'd4000,  1'b0, 16'hffff,  16'hffff,  40'hff_ff_ff_ff_ff, 1'b1, 0,  1'b1,
        frame_from_bits(40'hff_ff_ff_ff_ff, 1'b0)},
      '{16'd4000,  1'b1, 16'd1234,  16'd80,    40'h01_02_03_04_0a, 1'b0, 0,  1'b1,
        frame_from_bits(40'h01_02_03_04_0a, 1'b1)},
      '{16'd4000,  1'b0, 16'd100,   16'd8000,  40'hff_ff_01_01_00, 1'b0, 0,  1'b1,
        frame_from_bits(40'hff_ff_01_01_00, 1'b1)},
      // Starts just below the top of the timer so that the intervals wrap.
      '{16'd4000,  1'b1, 16'd65000, 16'd500,   40'h12_34_56_78_00, 1'b0, 0,  1'b1,
        frame_from_bits(40'h12_34_56_78_00, 1'b0)},
      // Restart in the middle of a frame, then a full frame from the cleared state.
      '{16'd4000,  1'b0, 16'd7,     16'd3,     40'h5a_a5_c3_3c_00, 1'b0, 17, 1'b0, '0},
      '{16'd4000,  1'b0, 16'd40000, 16'd90,    40'h3c_c3_a5_5a_fe, 1'b0, 0,  1'b0, '0},
      '{16'd0,     1'b1, 16'd0,     16'd0,     40'hff_ff_ff_ff_ff, 1'b0, 0,  1'b1,
        frame_from_bits(40'hff_ff_ff_ff_ff, 1'b0)},
      '{16'd65535, 1'b1, 16'd0,     16'd1,     40'haa_55_f0_0f_fe, 1'b1, 0,  1'b1,
        frame_from_bits(40'haa_55_f0_0f_fe, 1'b1)},
      '{16'd65535, 1'b0, 16'hffff,  16'd2,     40'h80_00_00_00_80, 1'b0, 0,  1'b1,
        frame_from_bits(40'h80_00_00_00_80, 1'b1)},
      '{16'd1,     1'b1, 16'd20,    16'd0,     40'h00_00_00_00_01, 1'b0, 0,  1'b1,
        frame_from_bits(40'h00_00_00_00_01, 1'b0)},
      '{16'd4000,  1'b1, 16'd33,    16'd4000,  40'h7f_80_00_01_00, 1'b0, 0,  1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first row runs at the reset threshold, so no write comes before it.
    foreach (plan[i]) begin
      if (plan[i].thr != threshold) set_threshold(plan[i].thr);
      send_frame(plan[i].lead_restart, plan[i].t0, plan[i].resp, plan[i].pattern,
                 plan[i].exact, plan[i].stop_after, plan[i].typed, plan[i].want);
    end

    // Random part: mostly well-formed frames with random content, mixed with noise beats,
    // aborted frames and pauses, at a threshold that changes now and then.
    step = 0;
    while (beats_sent < 1400) begin
      if (step % 8 == 7) set_threshold(pick_threshold());
      tx_bursts = (beats_sent < 1250) && ($urandom_range(3) != 0);
      rx_bursts = (beats_sent < 1250) && ($urandom_range(3) != 0);
      if (step == 3) begin
        // The receiver stalls while frames keep arriving, so both output slots fill and
        // the decoder has to hold off its input.
        hold_long = 1'b1;
        tx_bursts = 1'b0;
        repeat (4) send_frame(1'b1, 16'($urandom), 16'($urandom),
                              rand_pattern(1'($urandom_range(1))), 1'b0, 0, 1'b0, '0);
      end else begin
        kind = $urandom_range(9);
        case (kind)
          0: repeat ($urandom_range(6, 1)) begin
               send_beat(sws_pkg::req_type_e'($urandom_range(1)), 16'($urandom), 1'b0, '0);
             end
          1: send_frame(1'($urandom_range(1)), 16'($urandom), 16'($urandom),
                        rand_pattern(1'b1), 1'b0, $urandom_range(41, 1), 1'b0, '0);
          2: drain_wait();
          default: send_frame($urandom_range(9) < 6, 16'($urandom), 16'($urandom),
                              rand_pattern(1'($urandom_range(1))), $urandom_range(7) == 0,
                              0, 1'b0, '0);
        endcase
      end
      step++;
    end

    // Let the last frames out, then keep watching the output for anything unexpected to appear.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
